@@ hdl/afrc_pkg.sv @@
// Package for the A/B flash record classifier: word types, class codes,
// magic tag tables, flag positions and the byte-wise CRC32 step.
// No dependencies.
package afrc_pkg;

  localparam int POS_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [15:0] DESC_CRC_AT = 16'd36;
  localparam logic [15:0] DESC_END    = 16'd40;
  localparam logic [15:0] HDR_CRC_AT  = 16'd28;
  localparam logic [15:0] HDR_SIZE    = 16'd32;

  localparam int F_OWNER  = 0;
  localparam int F_BODY   = 1;
  localparam int F_COMMIT = 2;
  localparam int F_TAIL   = 3;
  localparam int F_ALLFF  = 4;

  localparam logic [1:0] ACTIVE_NONE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERASED    = 2'd0,
    KIND_UNKNOWN   = 2'd1,
    KIND_OWNED     = 2'd2,
    KIND_COMMITTED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWNER  = 2'd0,
    REG_BODY   = 2'd1,
    REG_COMMIT = 2'd2,
    REG_TAIL   = 2'd3
  } region_t;

  typedef struct packed {
    logic       slot_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  first_kind;
    logic [1:0]  second_kind;
    logic [31:0] first_generation;
    logic [31:0] second_generation;
    logic [9:0]  first_length;
    logic [9:0]  second_length;
    logic        order_ok;
    logic [1:0]  active_slot;
    logic        target_slot;
    logic [31:0] next_generation;
    logic        save_allowed;
  } out_item_t;

  typedef struct packed {
    logic             slot;
    logic [7:0]       data;
    region_t          region;
    logic [POS_W-1:0] off;
    logic             last;
  } fe_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] gen;
    logic [9:0]  len;
  } summary_t;

  localparam logic [7:0] OWNER_TAG [16] = '{
    8'h53, 8'h32, 8'h50, 8'h52, 8'h4F, 8'h42, 8'h45, 8'h2D,
    8'h50, 8'h41, 8'h49, 8'h52, 8'h49, 8'h4E, 8'h47, 8'h00};
  localparam logic [7:0] BODY_TAG [8] = '{
    8'h53, 8'h32, 8'h50, 8'h41, 8'h49, 8'h52, 8'h30, 8'h31};
  localparam logic [7:0] COMMIT_TAG [16] = '{
    8'h53, 8'h32, 8'h50, 8'h41, 8'h49, 8'h52, 8'h2D, 8'h43,
    8'h4F, 8'h4D, 8'h4D, 8'h49, 8'h54, 8'h54, 8'h45, 8'h44};

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  function automatic summary_t make_summary(input logic [5:0] flags, input logic crc_eq,
                                            input logic fits, input logic [31:0] gen,
                                            input logic [9:0] len);
    summary_t s;
    s = '{kind: KIND_ERASED, gen: 32'd0, len: 10'd0};
    if (!flags[F_OWNER]) begin
      s.kind = flags[F_ALLFF] ? KIND_ERASED : KIND_UNKNOWN;
    end else if (!flags[F_TAIL]) begin
      s.kind = KIND_UNKNOWN;
    end else if (flags[F_BODY] && flags[F_COMMIT] && crc_eq && fits) begin
      s.kind = KIND_COMMITTED;
      s.gen  = gen;
      s.len  = len;
    end else begin
      s.kind = KIND_OWNED;
    end
    return s;
  endfunction

endpackage

@@ hdl/afrc_front.sv @@
// Front end: accepts words, tracks the position within the sector and tags
// each byte with its record region and offset. Depends on afrc_pkg.
module afrc_front #(
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int MAX_PAYLOAD  = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afrc_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output afrc_pkg::fe_item_t q_item
);
  import afrc_pkg::*;

  localparam int PW         = $clog2(SECTOR_BYTES);
  localparam int BODY_AT    = PAGE_BYTES;
  localparam int BODY_SPAN  = ((32 + MAX_PAYLOAD + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
  localparam int COMMIT_AT  = BODY_AT + BODY_SPAN;
  localparam int RECORD_END = COMMIT_AT + PAGE_BYTES;

  logic [PW-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0] rel;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign rel      = POS_W'(pos_r);

  always_comb begin
    q_item.slot = in_item.slot_index;
    q_item.data = in_item.data_byte;
    q_item.last = (pos_r == PW'(SECTOR_BYTES - 1));
    if (32'(rel) < 32'(BODY_AT)) begin
      q_item.region = REG_OWNER;
      q_item.off    = rel;
    end else if (32'(rel) < 32'(COMMIT_AT)) begin
      q_item.region = REG_BODY;
      q_item.off    = rel - POS_W'(BODY_AT);
    end else if (32'(rel) < 32'(RECORD_END)) begin
      q_item.region = REG_COMMIT;
      q_item.off    = rel - POS_W'(COMMIT_AT);
    end else begin
      q_item.region = REG_TAIL;
      q_item.off    = rel;
    end
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = q_item.last ? '0 : pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ hdl/afrc_fifo.sv @@
// Short queue of tagged bytes between the front end and the parser.
// Depends on afrc_pkg.
module afrc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  afrc_pkg::fe_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output afrc_pkg::fe_item_t pop_item
);
  import afrc_pkg::*;

  fe_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

@@ hdl/afrc_back.sv @@
// Parser and arbiter: checks each tagged byte, keeps the CRCs and record
// fields, compares payloads and produces the slot decision. Depends on afrc_pkg.
module afrc_back #(
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int MAX_PAYLOAD  = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                q_valid,
  input  afrc_pkg::fe_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output afrc_pkg::out_item_t out_item
);
  import afrc_pkg::*;

  localparam int BODY_SPAN  = ((32 + MAX_PAYLOAD + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
  localparam int RECORD_END = PAGE_BYTES + BODY_SPAN + PAGE_BYTES;
  localparam logic FITS     = (RECORD_END <= SECTOR_BYTES);
  localparam int LW         = $clog2(MAX_PAYLOAD + 1);
  localparam int MW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [31:0]   base_r;
  logic [31:0]   crc_r, crc_nxt, cw_r, cw_nxt, gen_r, gen_nxt;
  logic [31:0]   spc_r, spc_nxt, shc_r, shc_nxt, chc_r, chc_nxt, pcrc_r, pcrc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [5:0]    flags_r, flags_nxt;
  logic          pm_r;
  summary_t      first_r;
  logic [7:0]    store_r [MAX_PAYLOAD];
  logic [7:0]    rd_r, cmp_byte_r;
  logic          cmp_v_r, cmp_en;
  logic          mem_we;
  logic [MW-1:0] idx;
  logic          fin_v_r, fin_move, fin_pm_r;
  summary_t      fin_s0_r, fin_s1_r, cur_sum;
  out_item_t     out_r, res;
  logic          out_v_r;

  logic [7:0]       b;
  logic [31:0]      w, own_off, crc_b;
  logic [POS_W-1:0] off, pi;

  assign fin_move  = fin_v_r && (!out_v_r || out_ready);
  assign q_pop     = q_valid && (!fin_v_r || fin_move);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_comb begin
    b         = q_item.data;
    off       = q_item.off;
    pi        = off - HDR_SIZE;
    idx       = pi[MW-1:0];
    crc_b     = crc_byte(crc_r, b);
    own_off   = base_r + (q_item.slot ? 32'(SECTOR_BYTES) : 32'd0);
    cw_nxt    = {b, cw_r[31:8]};
    w         = cw_nxt;
    crc_nxt   = crc_r;
    flags_nxt = flags_r;
    gen_nxt   = gen_r;
    len_nxt   = len_r;
    spc_nxt   = spc_r;
    shc_nxt   = shc_r;
    chc_nxt   = chc_r;
    pcrc_nxt  = pcrc_r;
    mem_we    = 1'b0;
    cmp_en    = 1'b0;
    if (b != 8'hff) flags_nxt[F_ALLFF] = 1'b0;
    case (q_item.region)
      REG_OWNER: begin
        if (off < DESC_CRC_AT) crc_nxt = crc_b;
        if (off < 16'd16 && b != OWNER_TAG[off[3:0]]) flags_nxt[F_OWNER] = 1'b0;
        if (off >= DESC_END && b != 8'hff) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd19 && w != 32'd1) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd23 && w != own_off) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd27 && w != 32'(MAX_PAYLOAD)) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd31 && w != 32'(PAGE_BYTES)) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd35 && w != 32'(SECTOR_BYTES)) flags_nxt[F_OWNER] = 1'b0;
        if (off == 16'd39) begin
          if (w != ~crc_r) flags_nxt[F_OWNER] = 1'b0;
          crc_nxt = '1;
        end
      end
      REG_BODY: begin
        if (off < HDR_CRC_AT) begin
          crc_nxt = crc_b;
          if (off == HDR_CRC_AT - 16'd1) begin
            chc_nxt = ~crc_b;
            crc_nxt = '1;
          end
        end
        if (off < 16'd8 && b != BODY_TAG[off[2:0]]) flags_nxt[F_BODY] = 1'b0;
        if (off == 16'd11) gen_nxt = w;
        if (off == 16'd15 && w != ~gen_r) flags_nxt[F_BODY] = 1'b0;
        if (off == 16'd19) begin
          if (w != 32'd0 && w <= 32'(MAX_PAYLOAD)) begin
            len_nxt = w[LW-1:0];
          end else begin
            len_nxt = '0;
            flags_nxt[F_BODY] = 1'b0;
          end
        end
        if (off == 16'd23) spc_nxt = w;
        if (off == 16'd27 && w != 32'(HDR_SIZE)) flags_nxt[F_BODY] = 1'b0;
        if (off == 16'd31) begin
          shc_nxt = w;
          if (w != chc_r) flags_nxt[F_BODY] = 1'b0;
        end
        if (off >= HDR_SIZE) begin
          if (pi < POS_W'(len_r)) begin
            crc_nxt = crc_b;
            if (pi + 16'd1 == POS_W'(len_r)) begin
              pcrc_nxt = ~crc_b;
              crc_nxt  = '1;
            end
          end else if (b != 8'hff) begin
            flags_nxt[F_BODY] = 1'b0;
          end
          if (32'(pi) < 32'(MAX_PAYLOAD)) begin
            if (!q_item.slot) mem_we = 1'b1;
            else if (pi < POS_W'(len_r)) cmp_en = 1'b1;
          end
        end
      end
      REG_COMMIT: begin
        if (off < DESC_CRC_AT) crc_nxt = crc_b;
        if (off < 16'd16 && b != COMMIT_TAG[off[3:0]]) flags_nxt[F_COMMIT] = 1'b0;
        if (off >= DESC_END && b != 8'hff) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd19 && w != gen_r) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd23 && w != shc_r) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd27 && w != spc_r) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd31 && w != 32'(len_r)) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd35 && w != own_off) flags_nxt[F_COMMIT] = 1'b0;
        if (off == 16'd39) begin
          if (w != ~crc_r) flags_nxt[F_COMMIT] = 1'b0;
          crc_nxt = '1;
        end
      end
      REG_TAIL: begin
        if (b != 8'hff) flags_nxt[F_TAIL] = 1'b0;
      end
      default: begin
        flags_nxt = flags_r;
      end
    endcase
    cur_sum = make_summary(flags_nxt, pcrc_nxt == spc_nxt, FITS, gen_nxt, 10'(len_nxt));
  end

  always_ff @(posedge clk) begin
    if (mem_we && q_pop) begin
      store_r[idx] <= b;
    end
    if (q_pop) begin
      rd_r       <= store_r[idx];
      cmp_byte_r <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      crc_r    <= '1;
      cw_r     <= '0;
      gen_r    <= '0;
      len_r    <= '0;
      spc_r    <= '0;
      shc_r    <= '0;
      chc_r    <= '0;
      pcrc_r   <= '0;
      flags_r  <= '1;
      pm_r     <= 1'b1;
      first_r  <= '0;
      cmp_v_r  <= 1'b0;
      fin_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      cmp_v_r <= q_pop && cmp_en;
      if (q_pop && q_item.last) begin
        pm_r <= 1'b1;
      end else if (cmp_v_r && rd_r != cmp_byte_r) begin
        pm_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.last) begin
          crc_r   <= '1;
          cw_r    <= '0;
          gen_r   <= '0;
          len_r   <= '0;
          spc_r   <= '0;
          shc_r   <= '0;
          chc_r   <= '0;
          pcrc_r  <= '0;
          flags_r <= '1;
          if (!q_item.slot) begin
            first_r <= cur_sum;
          end else begin
            first_r <= '0;
          end
        end else begin
          crc_r   <= crc_nxt;
          cw_r    <= cw_nxt;
          gen_r   <= gen_nxt;
          len_r   <= len_nxt;
          spc_r   <= spc_nxt;
          shc_r   <= shc_nxt;
          chc_r   <= chc_nxt;
          pcrc_r  <= pcrc_nxt;
          flags_r <= flags_nxt;
        end
      end
      if (q_pop && q_item.last && q_item.slot) begin
        fin_v_r <= 1'b1;
      end else if (fin_move) begin
        fin_v_r <= 1'b0;
      end
      if (fin_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last && q_item.slot) begin
      fin_s0_r <= first_r;
      fin_s1_r <= cur_sum;
      fin_pm_r <= pm_r;
    end
    if (fin_move) begin
      out_r <= res;
    end
  end

  always_comb begin
    logic [31:0] diff;
    logic        ok;
    logic [1:0]  act;
    diff = fin_s1_r.gen - fin_s0_r.gen;
    ok   = 1'b1;
    act  = ACTIVE_NONE;
    if (fin_s0_r.kind == KIND_COMMITTED && fin_s1_r.kind == KIND_COMMITTED) begin
      act = 2'd0;
      if (diff == 32'd0) begin
        if (fin_s0_r.len != fin_s1_r.len || !fin_pm_r) ok = 1'b0;
      end else if (diff == 32'h80000000) begin
        ok = 1'b0;
      end else if (diff < 32'h80000000) begin
        act = 2'd1;
      end
    end else if (fin_s0_r.kind == KIND_COMMITTED) begin
      act = 2'd0;
    end else if (fin_s1_r.kind == KIND_COMMITTED) begin
      act = 2'd1;
    end
    res.first_kind        = fin_s0_r.kind;
    res.second_kind       = fin_s1_r.kind;
    res.first_generation  = fin_s0_r.gen;
    res.second_generation = fin_s1_r.gen;
    res.first_length      = fin_s0_r.len;
    res.second_length     = fin_s1_r.len;
    res.order_ok          = ok;
    if (!ok) begin
      res.active_slot     = ACTIVE_NONE;
      res.target_slot     = 1'b0;
      res.next_generation = 32'd0;
    end else if (act != ACTIVE_NONE) begin
      res.active_slot     = act;
      res.target_slot     = !act[0];
      res.next_generation = (act[0] ? fin_s1_r.gen : fin_s0_r.gen) + 32'd1;
    end else begin
      res.active_slot     = ACTIVE_NONE;
      res.target_slot     = (fin_s0_r.kind != KIND_ERASED);
      res.next_generation = 32'd1;
    end
    res.save_allowed = fin_s0_r.kind != KIND_UNKNOWN && fin_s1_r.kind != KIND_UNKNOWN && ok;
  end

endmodule

@@ hdl/ab_flash_record_classifier_core.sv @@
// A/B flash record classifier, top level: front end, queue and parser.
// Depends on afrc_pkg, afrc_front, afrc_fifo and afrc_back.
//
// The block takes one byte word per cycle while the queue has room, slot 0 sector
// first and then slot 1, and presents one result word once the last byte of
// slot 1 has passed the queue and the finish and output registers. A four-entry
// queue separates the byte counter from the parser, whose CRC step and field
// checks handle one byte per cycle; the parser stalls only when a finished result
// is still waiting at the output. No clearing pass is needed after reset.
module ab_flash_record_classifier_core #(
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256,
  parameter int MAX_PAYLOAD  = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  afrc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output afrc_pkg::out_item_t out_item
);
  import afrc_pkg::*;

  logic     q_full, q_push, q_pop, q_valid;
  fe_item_t q_in, q_out;

  afrc_front #(
    .SECTOR_BYTES(SECTOR_BYTES), .PAGE_BYTES(PAGE_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  afrc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_item(q_out)
  );

  afrc_back #(
    .SECTOR_BYTES(SECTOR_BYTES), .PAGE_BYTES(PAGE_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue read while empty");
  a_active_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.active_slot != 2'd3) else $error("bad active slot");
  a_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.order_ok) |->
      (out_item.active_slot == ACTIVE_NONE && out_item.next_generation == 32'd0 &&
       !out_item.save_allowed)) else $error("conflict result inconsistent");
`endif

endmodule
